[hw/rtl/cdwe_pkg.sv]
// Shared types, constants and calendar helper functions of the calendar date weekday engine.
// Used by cdwe_ucode_rom, calendar_date_weekday_engine and calendar_date_checker; depends on nothing else.
`default_nettype none

package cdwe_pkg;

  // Highest year that counts as valid.
  localparam logic [12:0] YearMax = 13'd4095;

  localparam int StepW = 4;
  typedef logic [StepW-1:0] step_t;

  // Addresses of the steps of the control program.
  localparam step_t StepInit      = 4'd0;
  localparam step_t StepYearTest  = 4'd1;
  localparam step_t StepYearStep  = 4'd2;
  localparam step_t StepMonthInit = 4'd3;
  localparam step_t StepMonthTest = 4'd4;
  localparam step_t StepMonthStep = 4'd5;
  localparam step_t StepDayAdd    = 4'd6;
  localparam step_t StepSetWd     = 4'd7;
  localparam step_t StepAdvance   = 4'd8;
  localparam step_t StepFinishOk  = 4'd9;
  localparam step_t StepFinishBad = 4'd10;

  typedef enum logic [3:0] {
    OpNop,
    OpInit,
    OpYearStep,
    OpMonthInit,
    OpMonthStep,
    OpDayAdd,
    OpSetWd,
    OpAdvance,
    OpFinishOk,
    OpFinishBad
  } op_e;

  typedef enum logic [2:0] {
    CondAlways,
    CondBadFields,
    CondYearDone,
    CondDayOver,
    CondMonthDone,
    CondCountLast
  } cond_e;

  // One control word: the operation, the branch condition and both targets.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jt;
    step_t jf;
  } ctrl_t;

  // Length of a month; month must be 1 to 12.
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    begin
      case (month)
        4'd2: begin
          n = leap ? 5'd29 : 5'd28;
        end
        4'd4, 4'd6, 4'd9, 4'd11: begin
          n = 5'd30;
        end
        default: begin
          n = 5'd31;
        end
      endcase
      return n;
    end
  endfunction

  // Remainder by seven of a five-bit value.
  function automatic logic [2:0] mod7(input logic [4:0] v);
    logic [4:0] r;
    begin
      if (v < 5'd7) begin
        r = v;
      end else if (v < 5'd14) begin
        r = v - 5'd7;
      end else if (v < 5'd21) begin
        r = v - 5'd14;
      end else if (v < 5'd28) begin
        r = v - 5'd21;
      end else begin
        r = v - 5'd28;
      end
      return r[2:0];
    end
  endfunction

  // Sum of two residues modulo seven.
  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) begin
        s = s - 4'd7;
      end
      return s[2:0];
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cdwe_ucode_rom.sv]
// Control store of the calendar date weekday engine: one control word per program step.
// Depends on cdwe_pkg for the control word type and the step addresses.
`default_nettype none

module cdwe_ucode_rom (
  input  cdwe_pkg::step_t pc_i,
  output cdwe_pkg::ctrl_t ctrl_o
);

  always_comb begin
    ctrl_o = '{op: cdwe_pkg::OpNop, cond: cdwe_pkg::CondAlways,
               jt: cdwe_pkg::StepFinishBad, jf: cdwe_pkg::StepFinishBad};
    case (pc_i)
      cdwe_pkg::StepInit: begin
        ctrl_o = '{op: cdwe_pkg::OpInit, cond: cdwe_pkg::CondBadFields,
                   jt: cdwe_pkg::StepFinishBad, jf: cdwe_pkg::StepYearTest};
      end
      cdwe_pkg::StepYearTest: begin
        ctrl_o = '{op: cdwe_pkg::OpNop, cond: cdwe_pkg::CondYearDone,
                   jt: cdwe_pkg::StepMonthInit, jf: cdwe_pkg::StepYearStep};
      end
      cdwe_pkg::StepYearStep: begin
        ctrl_o = '{op: cdwe_pkg::OpYearStep, cond: cdwe_pkg::CondAlways,
                   jt: cdwe_pkg::StepYearTest, jf: cdwe_pkg::StepYearTest};
      end
      cdwe_pkg::StepMonthInit: begin
        ctrl_o = '{op: cdwe_pkg::OpMonthInit, cond: cdwe_pkg::CondDayOver,
                   jt: cdwe_pkg::StepFinishBad, jf: cdwe_pkg::StepMonthTest};
      end
      cdwe_pkg::StepMonthTest: begin
        ctrl_o = '{op: cdwe_pkg::OpNop, cond: cdwe_pkg::CondMonthDone,
                   jt: cdwe_pkg::StepDayAdd, jf: cdwe_pkg::StepMonthStep};
      end
      cdwe_pkg::StepMonthStep: begin
        ctrl_o = '{op: cdwe_pkg::OpMonthStep, cond: cdwe_pkg::CondAlways,
                   jt: cdwe_pkg::StepMonthTest, jf: cdwe_pkg::StepMonthTest};
      end
      cdwe_pkg::StepDayAdd: begin
        ctrl_o = '{op: cdwe_pkg::OpDayAdd, cond: cdwe_pkg::CondAlways,
                   jt: cdwe_pkg::StepSetWd, jf: cdwe_pkg::StepSetWd};
      end
      cdwe_pkg::StepSetWd: begin
        ctrl_o = '{op: cdwe_pkg::OpSetWd, cond: cdwe_pkg::CondAlways,
                   jt: cdwe_pkg::StepAdvance, jf: cdwe_pkg::StepAdvance};
      end
      cdwe_pkg::StepAdvance: begin
        ctrl_o = '{op: cdwe_pkg::OpAdvance, cond: cdwe_pkg::CondCountLast,
                   jt: cdwe_pkg::StepFinishOk, jf: cdwe_pkg::StepAdvance};
      end
      cdwe_pkg::StepFinishOk: begin
        ctrl_o = '{op: cdwe_pkg::OpFinishOk, cond: cdwe_pkg::CondAlways,
                   jt: cdwe_pkg::StepInit, jf: cdwe_pkg::StepInit};
      end
      cdwe_pkg::StepFinishBad: begin
        ctrl_o = '{op: cdwe_pkg::OpFinishBad, cond: cdwe_pkg::CondAlways,
                   jt: cdwe_pkg::StepInit, jf: cdwe_pkg::StepInit};
      end
      default: begin
        ctrl_o = '{op: cdwe_pkg::OpNop, cond: cdwe_pkg::CondAlways,
                   jt: cdwe_pkg::StepFinishBad, jf: cdwe_pkg::StepFinishBad};
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/calendar_date_weekday_engine.sv]
// Top level of the calendar date weekday engine: microcoded sequencer and its datapath.
// Depends on cdwe_pkg and on cdwe_ucode_rom, the control store.
//
// Usage. One date word enters on the slave stream (year, month, day) and one result word
// leaves on the master stream. The tuser bit of the result says whether the date exists;
// when it is low every field of tdata is zero. Otherwise tdata carries the following date,
// the weekday (1 for Monday to 7 for Sunday) and the date of the first Monday strictly
// after the input date.
// Operation. A short control program steps a small datapath. The weekday is found by
// walking the years from year 1 and then the months of the input year, each with a test
// step and an update step, keeping the day count modulo seven; the cursor then steps one
// day per cycle to the next Monday (one to seven days). A date with a bad year, month or
// day field is rejected at the first step of the program; one whose day lies past the end
// of its month only once the year walk is done. One date is worked at a time; the year
// loop of the sequencer sets the rate.
// Stalls. The result sits in an output register, so a new date is taken as soon as the
// sequencer is free, even while the receiver holds off the previous result. If that result
// is still waiting when the next one is ready, the sequencer holds on its final step.
// Reset. The asynchronous active-low reset empties the output register and stops the
// sequencer; the block then waits for a date.
`default_nettype none

module calendar_date_weekday_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Date in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // year[11:0], month[15:12], day[20:16], zero[23:21]
  // Result out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // next_year[12:0], next_month[16:13], next_day[21:17],
                                      // weekday[24:22], monday_year[37:25],
                                      // monday_month[41:38], monday_day[46:42], zero[47]
  output logic        m_axis_tuser    // date_valid
);

  // Sequencer control state.
  logic             busy_q, busy_d;
  cdwe_pkg::step_t  pc_q, pc_d;
  logic             out_valid_q, out_valid_d;
  cdwe_pkg::ctrl_t  ctrl;

  // Input date held for the whole program.
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;

  // Year walk: current year with its residues by 100 and by 400 (in centuries).
  logic [11:0] yy_q, yy_d;
  logic [6:0]  mod100_q, mod100_d;
  logic [1:0]  cent_q, cent_d;
  logic [2:0]  w_q, w_d;          // day count modulo seven
  logic [3:0]  k_q, k_d;          // month walk
  logic [2:0]  wd_q, wd_d;        // weekday
  logic [2:0]  cnt_q, cnt_d;      // days left to the next Monday

  // Date cursor stepped day by day towards the next Monday.
  logic [12:0] cy_q, cy_d;
  logic [3:0]  cm_q, cm_d;
  logic [4:0]  cd_q, cd_d;
  logic        first_q, first_d;
  logic [12:0] ny_q, ny_d;
  logic [3:0]  nm_q, nm_d;
  logic [4:0]  nd_q, nd_d;

  // Output register.
  logic [47:0] out_data_q, out_data_d;
  logic        out_user_q, out_user_d;

  // Datapath views.
  logic        leap;
  logic        cond_true;
  logic        finishing;
  logic        stall;
  logic        accept;
  logic        take_out;
  logic [12:0] adv_y;
  logic [3:0]  adv_m;
  logic [4:0]  adv_d;
  logic [4:0]  month_len;

  cdwe_ucode_rom u_rom (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && !busy_q;
  assign take_out      = out_valid_q && m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The year counters stand still once the walk reaches the input year, so this is then
  // the leap flag of the input year.
  assign leap = ((yy_q[1:0] == 2'b00) && (mod100_q != 7'd0))
             || ((mod100_q == 7'd0) && (cent_q == 2'd0));

  // One day forward from the cursor. The cursor leaves the input year only into January,
  // where the leap flag plays no part.
  always_comb begin
    month_len = cdwe_pkg::days_in(cm_q, leap);
    adv_y     = cy_q;
    adv_m     = cm_q;
    adv_d     = cd_q + 5'd1;
    if (cd_q >= month_len) begin
      adv_d = 5'd1;
      if (cm_q == 4'd12) begin
        adv_m = 4'd1;
        adv_y = cy_q + 13'd1;
      end else begin
        adv_m = cm_q + 4'd1;
      end
    end
  end

  always_comb begin
    case (ctrl.cond)
      cdwe_pkg::CondAlways: begin
        cond_true = 1'b1;
      end
      cdwe_pkg::CondBadFields: begin
        cond_true = (year_q == 12'd0) || ({1'b0, year_q} > cdwe_pkg::YearMax)
                 || (month_q == 4'd0) || (month_q > 4'd12) || (day_q == 5'd0);
      end
      cdwe_pkg::CondYearDone: begin
        cond_true = (yy_q == year_q);
      end
      cdwe_pkg::CondDayOver: begin
        cond_true = (day_q > cdwe_pkg::days_in(month_q, leap));
      end
      cdwe_pkg::CondMonthDone: begin
        cond_true = (k_q == month_q);
      end
      cdwe_pkg::CondCountLast: begin
        cond_true = (cnt_q == 3'd1);
      end
      default: begin
        cond_true = 1'b1;
      end
    endcase
  end

  assign finishing = (ctrl.op == cdwe_pkg::OpFinishOk) || (ctrl.op == cdwe_pkg::OpFinishBad);
  // A finished result waits here while the previous one is still held by the receiver.
  assign stall     = finishing && out_valid_q && !m_axis_tready;

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    yy_d        = yy_q;
    mod100_d    = mod100_q;
    cent_d      = cent_q;
    w_d         = w_q;
    k_d         = k_q;
    wd_d        = wd_q;
    cnt_d       = cnt_q;
    cy_d        = cy_q;
    cm_d        = cm_q;
    cd_d        = cd_q;
    first_d     = first_q;
    ny_d        = ny_q;
    nm_d        = nm_q;
    nd_d        = nd_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    if (take_out) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      year_d  = s_axis_tdata[11:0];
      month_d = s_axis_tdata[15:12];
      day_d   = s_axis_tdata[20:16];
      busy_d  = 1'b1;
      pc_d    = cdwe_pkg::StepInit;
    end else if (busy_q && !stall) begin
      pc_d = cond_true ? ctrl.jt : ctrl.jf;
      case (ctrl.op)
        cdwe_pkg::OpInit: begin
          yy_d     = 12'd1;
          mod100_d = 7'd1;
          cent_d   = 2'd0;
          w_d      = 3'd0;
        end
        cdwe_pkg::OpYearStep: begin
          w_d  = cdwe_pkg::add_mod7(w_q, leap ? 3'd2 : 3'd1);
          yy_d = yy_q + 12'd1;
          if (mod100_q == 7'd99) begin
            mod100_d = 7'd0;
            cent_d   = cent_q + 2'd1;
          end else begin
            mod100_d = mod100_q + 7'd1;
          end
        end
        cdwe_pkg::OpMonthInit: begin
          k_d = 4'd1;
        end
        cdwe_pkg::OpMonthStep: begin
          w_d = cdwe_pkg::add_mod7(w_q, cdwe_pkg::mod7(cdwe_pkg::days_in(k_q, leap)));
          k_d = k_q + 4'd1;
        end
        cdwe_pkg::OpDayAdd: begin
          w_d = cdwe_pkg::add_mod7(w_q, cdwe_pkg::mod7(day_q - 5'd1));
        end
        cdwe_pkg::OpSetWd: begin
          // Day zero of the count is a Monday.
          wd_d    = w_q + 3'd1;
          cnt_d   = 3'd7 - w_q;
          cy_d    = {1'b0, year_q};
          cm_d    = month_q;
          cd_d    = day_q;
          first_d = 1'b1;
        end
        cdwe_pkg::OpAdvance: begin
          cy_d    = adv_y;
          cm_d    = adv_m;
          cd_d    = adv_d;
          cnt_d   = cnt_q - 3'd1;
          first_d = 1'b0;
          if (first_q) begin
            ny_d = adv_y;
            nm_d = adv_m;
            nd_d = adv_d;
          end
        end
        cdwe_pkg::OpFinishOk: begin
          out_data_d  = {1'b0, cd_q, cm_q, cy_q, wd_q, nd_q, nm_q, ny_q};
          out_user_d  = 1'b1;
          out_valid_d = 1'b1;
          busy_d      = 1'b0;
        end
        cdwe_pkg::OpFinishBad: begin
          out_data_d  = '0;
          out_user_d  = 1'b0;
          out_valid_d = 1'b1;
          busy_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= cdwe_pkg::StepInit;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q     <= year_d;
    month_q    <= month_d;
    day_q      <= day_d;
    yy_q       <= yy_d;
    mod100_q   <= mod100_d;
    cent_q     <= cent_d;
    w_q        <= w_d;
    k_q        <= k_d;
    wd_q       <= wd_d;
    cnt_q      <= cnt_d;
    cy_q       <= cy_d;
    cm_q       <= cm_d;
    cd_q       <= cd_d;
    ny_q       <= ny_d;
    nm_q       <= nm_d;
    nd_q       <= nd_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

`ifndef NO_ASSERTIONS
  // An accepted date always starts the program from its first step.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> busy_q && (pc_q == cdwe_pkg::StepInit))
    else $error("accepted date did not start the program");

  // The program counter never leaves the written part of the control store.
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= cdwe_pkg::StepFinishBad))
    else $error("program counter out of range");

  // The Monday count is never exhausted while the cursor is still stepping.
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (pc_q == cdwe_pkg::StepAdvance) |-> (cnt_q != 3'd0))
    else $error("day count to Monday ran out");

  // A valid result carries a weekday, an invalid one carries nothing at all.
  a_weekday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[24:22] != 3'd0)))
    else $error("weekday does not match the valid flag");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 48'd0))
    else $error("invalid date with non-zero result fields");
`endif

endmodule

`default_nettype wire

[tb/calendar_date_checker.sv]
// Checker of the calendar date weekday engine: watches both streams, forecasts each result word
// from the accepted date word and compares them field by field.
// Depends on cdwe_pkg for the highest valid year.
`default_nettype none

module calendar_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          answers_pending,
  output int          dates_seen,
  output int          valid_dates
);
  timeunit 1ns;
  timeprecision 1ps;

  // Monday 2013-04-08 fixes the weekday of every other date.
  localparam int unsigned RefYear  = 2013;
  localparam int unsigned RefMonth = 4;
  localparam int unsigned RefDay   = 8;

  typedef struct packed {
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_date_t;

  typedef struct packed {
    logic        date_valid;
    logic [12:0] next_year;
    logic [3:0]  next_month;
    logic [4:0]  next_day;
    logic [2:0]  weekday;
    logic [12:0] monday_year;
    logic [3:0]  monday_month;
    logic [4:0]  monday_day;
  } calendar_answer_t;

  calendar_answer_t pending_answers[$];
  calendar_answer_t want;

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      2: begin
        return is_leap(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Days elapsed since 0001-01-01.
  function automatic int unsigned days_since_epoch(input int unsigned y, input int unsigned m,
                                                   input int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) begin
      n += month_days(y, k);
    end
    return n + d - 1;
  endfunction

  function automatic cal_date_t next_date(input cal_date_t dt);
    cal_date_t nd;
    nd = dt;
    if (dt.day < month_days(dt.year, dt.month)) begin
      nd.day = dt.day + 5'd1;
    end else begin
      nd.day = 5'd1;
      if (dt.month == 4'd12) begin
        nd.month = 4'd1;
        nd.year  = dt.year + 13'd1;
      end else begin
        nd.month = dt.month + 4'd1;
      end
    end
    return nd;
  endfunction

  function automatic calendar_answer_t predict_calendar_answer(input logic [11:0] year,
                                                               input logic [3:0]  month,
                                                               input logic [4:0]  day);
    calendar_answer_t ans;
    cal_date_t        today;
    cal_date_t        step;
    int unsigned      wd;
    ans = '0;
    // A rejected date leaves every field at zero.
    if (year == 12'd0 || {1'b0, year} > cdwe_pkg::YearMax || month == 4'd0 || month > 4'd12 ||
        day == 5'd0 || day > month_days(year, month)) begin
      return ans;
    end
    today          = {1'b0, year, month, day};
    step           = next_date(today);
    ans.date_valid = 1'b1;
    ans.next_year  = step.year;
    ans.next_month = step.month;
    ans.next_day   = step.day;
    wd = ((days_since_epoch(year, month, day) % 7 + 7 -
           days_since_epoch(RefYear, RefMonth, RefDay) % 7) % 7) + 1;
    ans.weekday = wd[2:0];
    // The next Monday lies 8 - weekday days ahead, so a Monday gives a week later.
    step = today;
    for (int unsigned k = 0; k < 8 - wd; k++) begin
      step = next_date(step);
    end
    ans.monday_year  = step.year;
    ans.monday_month = step.month;
    ans.monday_day   = step.day;
    return ans;
  endfunction

  task automatic compare_field(input string field, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count      = 0;
    answers_pending = 0;
    dates_seen      = 0;
    valid_dates     = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_answers.push_back(predict_calendar_answer(s_axis_tdata[11:0],
                                                          s_axis_tdata[15:12],
                                                          s_axis_tdata[20:16]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        dates_seen++;
        if (pending_answers.size() == 0) begin
          $error("result word arrived with no date word waiting for it");
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          if (want.date_valid) begin
            valid_dates++;
          end
          compare_field("date_valid", want.date_valid, m_axis_tuser);
          compare_field("next_year", want.next_year, m_axis_tdata[12:0]);
          compare_field("next_month", want.next_month, m_axis_tdata[16:13]);
          compare_field("next_day", want.next_day, m_axis_tdata[21:17]);
          compare_field("weekday", want.weekday, m_axis_tdata[24:22]);
          compare_field("monday_year", want.monday_year, m_axis_tdata[37:25]);
          compare_field("monday_month", want.monday_month, m_axis_tdata[41:38]);
          compare_field("monday_day", want.monday_day, m_axis_tdata[46:42]);
        end
      end
      answers_pending = pending_answers.size();
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Top of the calendar date weekday engine testbench: clock, reset, date word stimulus and
// result back-pressure, with the verdict. Depends on calendar_date_weekday_engine and on
// calendar_date_checker, which forecasts and compares every result word.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod = 10;
  // A hundred valid dates in year 4095, stalls included, stay well inside this bound.
  localparam int unsigned MaxCycles = 4_000_000;
  localparam int RandomDates = 75;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count;
  int answers_pending;
  int dates_seen;
  int valid_dates;

  // Percentages of cycles in which the sender holds back a word and the receiver stalls.
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 46;
  int unsigned cycle_count = 0;

  calendar_date_weekday_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  calendar_date_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .fail_count      (fail_count),
    .answers_pending (answers_pending),
    .dates_seen      (dates_seen),
    .valid_dates     (valid_dates)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // Watchdog: a hung sequencer or a lost word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MaxCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver decides afresh at every falling edge whether to take a result word.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Offers one date word, after a random number of idle cycles, and returns once the word
  // has been taken. The valid line stays high from one word to the next when no gap falls.
  task automatic send_date(input logic [11:0] year, input logic [3:0] month,
                           input logic [4:0] day);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {3'b000, day, month, year};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
  endtask

  // Mostly well-formed dates with random content, weighted towards the last days of a month
  // so that month and year carries come often; the rest is random noise in every field.
  // Small years keep the year walk of the sequencer short; a few reach the top of the range.
  task automatic send_random_date();
    int unsigned kind;
    int unsigned pick;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        year = 12'($urandom_range(1, 400));
      end else if (pick == 7) begin
        year = 12'($urandom_range(1, 4095));
      end else if (pick == 8) begin
        year = 12'(100 * $urandom_range(1, 40));
      end else begin
        year = 12'($urandom_range(3840, 4095));
      end
      month = 4'($urandom_range(1, 12));
      if ($urandom_range(0, 99) < 30) begin
        day = 5'($urandom_range(28, 31));
      end else begin
        day = 5'($urandom_range(1, 27));
      end
    end else begin
      year  = 12'($urandom_range(0, 4095));
      month = 4'($urandom_range(0, 15));
      day   = 5'($urandom_range(0, 31));
    end
    send_date(year, month, day);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed dates: the calendar's edges, the reference Monday and each kind of rejection.
    send_date(12'd1, 4'd1, 5'd1);        // first day of year one
    send_date(12'd2013, 4'd4, 5'd8);     // the reference Monday itself
    send_date(12'd2013, 4'd4, 5'd7);     // a Sunday, so the next Monday is tomorrow
    send_date(12'd4095, 4'd12, 5'd31);   // last valid year carries into 4096
    send_date(12'd4095, 4'd12, 5'd27);   // next Monday may lie beyond the last year
    send_date(12'd4095, 4'd1, 5'd1);
    send_date(12'd2000, 4'd2, 5'd29);    // leap day in a year divisible by 400
    send_date(12'd1900, 4'd2, 5'd29);    // no leap day in a plain century year
    send_date(12'd2024, 4'd2, 5'd29);
    send_date(12'd2023, 4'd2, 5'd29);
    send_date(12'd2023, 4'd2, 5'd28);    // end of a short February
    send_date(12'd1999, 4'd12, 5'd31);   // year carry
    send_date(12'd1600, 4'd12, 5'd31);
    send_date(12'd400, 4'd3, 5'd1);
    send_date(12'd2001, 4'd4, 5'd31);    // past the end of a thirty-day month
    send_date(12'd2047, 4'd1, 5'd31);
    send_date(12'd2730, 4'd10, 5'd21);
    send_date(12'd1365, 4'd5, 5'd10);
    send_date(12'd0, 4'd6, 5'd15);       // year zero
    send_date(12'd2000, 4'd0, 5'd10);    // month zero
    send_date(12'd2000, 4'd13, 5'd1);    // month just past December
    send_date(12'd2000, 4'd15, 5'd31);
    send_date(12'd2000, 4'd5, 5'd0);     // day zero
    send_date(12'd0, 4'd0, 5'd0);
    send_date(12'd4095, 4'd15, 5'd31);

    // Three stall patterns: light sender gaps with heavy back-pressure, the reverse, none.
    for (int i = 0; i < RandomDates; i++) begin
      if (i == RandomDates / 3) begin
        tx_idle_pct = 46;
        rx_idle_pct = 10;
      end else if (i == 2 * RandomDates / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random_date();
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    // Drain, then give a stray extra word time to show itself.
    wait (answers_pending == 0);
    repeat (100) @(posedge clk_i);

    $display("Covered %0d date words: %0d real dates and %0d rejected ones, under three stall",
             dates_seen, valid_dates, dates_seen - valid_dates);
    $display("patterns on both streams.");
    if (fail_count == 0 && answers_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
